// ----- rtl/core/ipv4hb_pkg.sv -----
`default_nettype none

package ipv4hb_pkg;

    localparam int HDR_WORDS = 10;
    localparam int WORD_W    = 16;
    localparam int IDX_W     = 4;
    localparam int ADDR_W    = 3;

    localparam logic [15:0] VER_IHL_TOS = 16'h4500;
    localparam logic [15:0] DF_FLAG     = 16'h4000;
    localparam logic [7:0]  TTL_VALUE   = 8'd64;
    localparam logic [15:0] HDR_BYTES   = 16'd20;
    localparam logic [15:0] BUF_BYTES   = 16'd1500;
    localparam logic [15:0] MAX_PAYLOAD = BUF_BYTES - HDR_BYTES;
    localparam logic [31:0] SRC_RESET   = 32'h0A00_020F;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HDR_WORDS - 1);

    // register index, taken from the word address bit above the byte offset, paddr[ADDR_W-1]
    localparam logic REG_SOURCE_ADDRESS = 1'b0;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [HDR_WORDS-1:0] t_header;

    typedef struct packed {
        logic [31:0] dest;
        logic [7:0]  proto;
        logic [15:0] plen;
    } t_request;

    typedef struct packed {
        logic act;
        logic last;
    } t_ser_status;

endpackage

`default_nettype wire

// ----- rtl/core/ipv4_header_builder_core.sv -----
`default_nettype none
// throughput: one oversized request per cycle; a good request holds the one-word result
// channel, which sets the rate, for its ten words, and the next request waits in the input register
// reset: synchronous active-low, source address returns to 10.0.2.15, no request in flight
// the receiver cannot stall; each word shows for one cycle with o_result_valid
module ipv4_header_builder_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [31:0]                   i_dest_address,
    input  wire logic [7:0]                    i_protocol_number,
    input  wire logic [15:0]                   i_payload_length,
    output logic                               o_result_valid,
    output logic [15:0]                        o_header_word,
    output logic [3:0]                         o_word_index,
    output logic                               o_last_word,
    output logic                               o_length_error,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ipv4hb_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import ipv4hb_pkg::*;

    t_request    r_req;
    logic        r_in_vld;
    logic        accept;
    logic        move;
    logic        ser_free;
    logic [31:0] source_address;
    t_header     words;
    logic        err;
    t_ser_status ser_status;

    ipv4hb_regs u_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_source_address (source_address)
    );

    // serializer can take a header when idle or on its final word
    assign ser_free = !ser_status.act || ser_status.last;
    assign move     = r_in_vld && ser_free;
    assign busy     = r_in_vld && !ser_free;
    assign accept   = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (move) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.dest  <= i_dest_address;
            r_req.proto <= i_protocol_number;
            r_req.plen  <= i_payload_length;
        end
    end

    ipv4hb_calc u_calc (
        .i_req            (r_req),
        .i_source_address (source_address),
        .o_words          (words),
        .o_err            (err)
    );

    ipv4hb_ser u_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (move),
        .i_words  (words),
        .i_err    (err),
        .o_status (ser_status),
        .o_word   (o_header_word),
        .o_idx    (o_word_index),
        .o_last   (o_last_word),
        .o_err    (o_length_error)
    );

    assign o_result_valid = ser_status.act;

endmodule

`default_nettype wire

// ----- rtl/core/ipv4hb_regs.sv -----
`default_nettype none

module ipv4hb_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ipv4hb_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output logic [31:0]                        o_source_address
);
    import ipv4hb_pkg::*;

    logic [31:0] r_source_address;
    logic        wr_en;
    logic        sel_src;

    assign sel_src = (paddr[ADDR_W-1] == REG_SOURCE_ADDRESS);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_address <= SRC_RESET;
        end else if (wr_en && sel_src) begin
            r_source_address <= pwdata;
        end
    end

    assign prdata           = sel_src ? r_source_address : 32'd0;
    assign o_source_address = r_source_address;

endmodule

`default_nettype wire

// ----- rtl/core/ipv4hb_calc.sv -----
`default_nettype none

module ipv4hb_calc (
    input  wire ipv4hb_pkg::t_request i_req,
    input  wire logic [31:0]          i_source_address,
    output ipv4hb_pkg::t_header       o_words,
    output logic                      o_err
);
    import ipv4hb_pkg::*;

    logic [15:0] total_len;
    logic [15:0] w_proto;
    logic [19:0] sum;
    logic [16:0] fold1;
    logic [16:0] fold2;
    logic [15:0] csum;

    assign o_err     = (i_req.plen > MAX_PAYLOAD);
    assign total_len = HDR_BYTES + i_req.plen;
    assign w_proto   = {TTL_VALUE, i_req.proto};

    always_comb begin
        sum = 20'(VER_IHL_TOS) + 20'(total_len) + 20'(DF_FLAG) + 20'(w_proto)
            + 20'(i_source_address[31:16]) + 20'(i_source_address[15:0])
            + 20'(i_req.dest[31:16]) + 20'(i_req.dest[15:0]);
        // end-around carry, two folds settle it
        fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
        fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
        csum  = ~fold2[15:0];
    end

    always_comb begin
        if (o_err) begin
            o_words = '0;
        end else begin
            o_words[0] = VER_IHL_TOS;
            o_words[1] = total_len;
            o_words[2] = '0;
            o_words[3] = DF_FLAG;
            o_words[4] = w_proto;
            o_words[5] = csum;
            o_words[6] = i_source_address[31:16];
            o_words[7] = i_source_address[15:0];
            o_words[8] = i_req.dest[31:16];
            o_words[9] = i_req.dest[15:0];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ipv4hb_ser.sv -----
`default_nettype none

module ipv4hb_ser (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_load,
    input  wire ipv4hb_pkg::t_header          i_words,
    input  wire logic                         i_err,
    output ipv4hb_pkg::t_ser_status           o_status,
    output logic [ipv4hb_pkg::WORD_W-1:0]     o_word,
    output logic [ipv4hb_pkg::IDX_W-1:0]      o_idx,
    output logic                              o_last,
    output logic                              o_err
);
    import ipv4hb_pkg::*;

    t_header          r_words;
    logic [IDX_W-1:0] r_idx;
    logic             r_err;
    logic             r_act;
    logic             last;

    // an error request stops after its single word
    assign last = r_err || (r_idx == LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_idx <= '0;
            r_err <= 1'b0;
        end else if (i_load) begin
            r_act <= 1'b1;
            r_idx <= '0;
            r_err <= i_err;
        end else if (r_act) begin
            if (last) begin
                r_act <= 1'b0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_words <= i_words;
        end else if (r_act) begin
            r_words <= {t_word'(0), r_words[HDR_WORDS-1:1]};
        end
    end

    assign o_status.act  = r_act;
    assign o_status.last = r_act && last;
    assign o_word        = r_words[0];
    assign o_idx         = r_idx;
    assign o_last        = last;
    assign o_err         = r_err;

endmodule

`default_nettype wire

// ----- rtl/core/ipv4hb_checker.sv -----
`default_nettype none

module ipv4hb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        busy,
    input wire logic        o_result_valid,
    input wire logic [15:0] o_header_word,
    input wire logic [3:0]  o_word_index,
    input wire logic        o_last_word,
    input wire logic        o_length_error
);
    import ipv4hb_pkg::*;

    // error request gives one zero word at index zero
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_length_error) |->
            (o_last_word && o_word_index == '0 && o_header_word == '0))
        else $error("error result malformed");

    // words of a header come on consecutive cycles
    a_word_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_last_word) |=>
            (o_result_valid && o_word_index == $past(o_word_index) + 4'd1))
        else $error("header word sequence broken");

    // final word of a good header is word nine
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_length_error) |->
            (o_last_word == (o_word_index == LAST_IDX)))
        else $error("last word at wrong index");

    // busy only while a header is streaming out
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (o_result_valid && !o_last_word))
        else $error("busy without header in flight");

endmodule

bind ipv4_header_builder_core ipv4hb_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_header_word  (o_header_word),
    .o_word_index   (o_word_index),
    .o_last_word    (o_last_word),
    .o_length_error (o_length_error)
);

`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none

typedef struct packed {
    logic [15:0] word;
    logic [3:0]  index;
    logic        last;
    logic        err;
} t_header_result;

class header_scoreboard;
    logic [31:0]    src_addr;
    t_header_result words_due[$];
    int             mismatches;

    function new();
        src_addr   = ipv4hb_pkg::SRC_RESET;
        mismatches = 0;
    endfunction

    function void set_source(logic [31:0] addr);
        src_addr = addr;
    endfunction

    function int pending();
        return words_due.size();
    endfunction

    function void flag_error();
        mismatches++;
    endfunction

    // builds the header words that one accepted request must produce
    function void note_request(ipv4hb_pkg::t_request req);
        logic [15:0]    hdr [10];
        logic [31:0]    acc;
        t_header_result res;
        if (req.plen > 16'd1480) begin
            res = '{word: 16'h0, index: 4'd0, last: 1'b1, err: 1'b1};
            words_due.push_back(res);
            return;
        end
        hdr[0] = 16'h4500;
        hdr[1] = req.plen + 16'd20;
        hdr[2] = 16'h0;
        hdr[3] = 16'h4000;
        hdr[4] = {8'd64, req.proto};
        hdr[5] = 16'h0;
        hdr[6] = src_addr[31:16];
        hdr[7] = src_addr[15:0];
        hdr[8] = req.dest[31:16];
        hdr[9] = req.dest[15:0];
        acc = 0;
        for (int k = 0; k < 10; k++) acc += hdr[k];
        while (acc[31:16] != 0) acc = acc[15:0] + acc[31:16];
        hdr[5] = ~acc[15:0];
        for (int k = 0; k < 10; k++) begin
            res = '{word: hdr[k], index: 4'(k), last: (k == 9), err: 1'b0};
            words_due.push_back(res);
        end
    endfunction

    function void check_word(t_header_result got);
        t_header_result want;
        if (words_due.size() == 0) begin
            $error("header word %h with no request waiting", got.word);
            mismatches++;
            return;
        end
        want = words_due.pop_front();
        if (got.word !== want.word) begin
            $error("header_word: expected %h, got %h", want.word, got.word);
            mismatches++;
        end
        if (got.index !== want.index) begin
            $error("word_index: expected %0d, got %0d", want.index, got.index);
            mismatches++;
        end
        if (got.last !== want.last) begin
            $error("last_word: expected %b, got %b", want.last, got.last);
            mismatches++;
        end
        if (got.err !== want.err) begin
            $error("length_error: expected %b, got %b", want.err, got.err);
            mismatches++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4hb_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_SOURCE = {REG_SOURCE_ADDRESS, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_SPARE  = 3'd4;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [31:0]       i_dest_address;
    logic [7:0]        i_protocol_number;
    logic [15:0]       i_payload_length;
    logic              o_result_valid;
    logic [15:0]       o_header_word;
    logic [3:0]        o_word_index;
    logic              o_last_word;
    logic              o_length_error;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    header_scoreboard hdr_sb;
    bit               gaps_on;

    ipv4_header_builder_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_dest_address    (i_dest_address),
        .i_protocol_number (i_protocol_number),
        .i_payload_length  (i_payload_length),
        .o_result_valid    (o_result_valid),
        .o_header_word     (o_header_word),
        .o_word_index      (o_word_index),
        .o_last_word       (o_last_word),
        .o_length_error    (o_length_error),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #1ms;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            hdr_sb.check_word('{word: o_header_word, index: o_word_index,
                                last: o_last_word, err: o_length_error});
    end

    // called at a falling edge; unless a random gap drops start, requests go back to back
    task automatic send_request(t_request req);
        start             = 1'b1;
        i_dest_address    = req.dest;
        i_protocol_number = req.proto;
        i_payload_length  = req.plen;
        do @(posedge i_clk); while (busy);
        hdr_sb.note_request(req);
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic reg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_SOURCE)
            hdr_sb.set_source(data);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_source_reg();
        logic [31:0] got;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_SOURCE;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got !== hdr_sb.src_addr) begin
            $error("source_address: expected %h, got %h", hdr_sb.src_addr, got);
            hdr_sb.flag_error();
        end
    endtask

    // lets the block drain before the register is touched
    task automatic wait_drained();
        start = 1'b0;
        while (hdr_sb.pending() != 0) @(posedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'($urandom_range(0, 1480));
        if (r < 80) begin
            case ($urandom_range(0, 3))
                0: return 16'd0;
                1: return 16'd1480;
                2: return 16'd1481;
                default: return 16'hFFFF;
            endcase
        end
        return 16'($urandom_range(1481, 65535));
    endfunction

    task automatic random_requests(int count);
        t_request req;
        for (int n = 0; n < count; n++) begin
            req.dest  = $urandom();
            req.proto = 8'($urandom_range(0, 255));
            req.plen  = pick_length();
            send_request(req);
        end
    endtask

    initial begin
        hdr_sb            = new();
        gaps_on           = 1'b1;
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_dest_address    = '0;
        i_protocol_number = '0;
        i_payload_length  = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset value of the source address
        check_source_reg();
        send_request('{dest: 32'hC0A8_0001, proto: 8'd6,   plen: 16'd0});
        send_request('{dest: 32'hFFFF_FFFF, proto: 8'd17,  plen: 16'd1480});
        send_request('{dest: 32'h0000_0000, proto: 8'd1,   plen: 16'd1481});
        send_request('{dest: 32'h1234_5678, proto: 8'd255, plen: 16'hFFFF});
        send_request('{dest: 32'h0A00_0001, proto: 8'd0,   plen: 16'd100});
        wait_drained();

        reg_write(ADDR_SOURCE, 32'h0000_0000);
        check_source_reg();
        send_request('{dest: 32'h0000_0000, proto: 8'd0,   plen: 16'd0});
        send_request('{dest: 32'hFFFF_FFFF, proto: 8'd255, plen: 16'd1480});
        send_request('{dest: 32'h7F00_0001, proto: 8'd1,   plen: 16'd1500});
        send_request('{dest: 32'h8000_0000, proto: 8'd6,   plen: 16'd20});
        wait_drained();

        reg_write(ADDR_SOURCE, 32'hFFFF_FFFF);
        check_source_reg();
        send_request('{dest: 32'hFFFF_FFFF, proto: 8'd255,  plen: 16'd1480});
        send_request('{dest: 32'h0000_0000, proto: 8'd0,    plen: 16'd0});
        send_request('{dest: 32'hAAAA_AAAA, proto: 8'd17,   plen: 16'h5555});
        send_request('{dest: 32'h5555_5555, proto: 8'h55,   plen: 16'h02AA});
        wait_drained();

        // a write to an unmapped register must leave the source address alone
        reg_write(ADDR_SPARE, $urandom());
        check_source_reg();
        send_request('{dest: 32'hC0A8_0102, proto: 8'd17, plen: 16'd512});
        wait_drained();

        for (int phase = 0; phase < 5; phase++) begin
            reg_write(ADDR_SOURCE, $urandom());
            check_source_reg();
            gaps_on = (phase < 4);
            random_requests(94);
            wait_drained();
        end

        start = 1'b0;
        while (hdr_sb.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (hdr_sb.mismatches == 0 && hdr_sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/ipv4hb_pkg.sv
rtl/core/ipv4hb_regs.sv
rtl/core/ipv4hb_calc.sv
rtl/core/ipv4hb_ser.sv
rtl/core/ipv4_header_builder_core.sv
rtl/core/ipv4hb_checker.sv
test/testbench.sv
